@@ sv/ry420_pkg.sv @@
// Package for the RGB24 to YUV 4:2:0 pixel stream: item types, register indexes, coefficients.
package ry420_pkg;

	localparam int CFG_W = 13;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_LINE_WIDTH   = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	typedef enum logic [1:0] {
		CK_NONE = 2'd0,
		CK_U    = 2'd1,
		CK_V    = 2'd2
	} chroma_kind_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0]   luma;
		logic [7:0]   chroma;
		chroma_kind_t chroma_kind;
		logic         line_end;
		logic         frame_end;
	} pixel_out_t;

	// BT.601 integer coefficients, 18-bit signed sums never overflow with 8-bit inputs
	localparam logic signed [17:0] Y_R = 18'sd66;
	localparam logic signed [17:0] Y_G = 18'sd129;
	localparam logic signed [17:0] Y_B = 18'sd25;
	localparam logic signed [17:0] U_R = -18'sd38;
	localparam logic signed [17:0] U_G = -18'sd74;
	localparam logic signed [17:0] U_B = 18'sd112;
	localparam logic signed [17:0] V_R = 18'sd112;
	localparam logic signed [17:0] V_G = -18'sd94;
	localparam logic signed [17:0] V_B = -18'sd18;
	localparam logic signed [17:0] ROUND     = 18'sd128;
	localparam logic signed [10:0] Y_OFFSET  = 11'sd16;
	localparam logic signed [10:0] C_OFFSET  = 11'sd128;
	localparam logic signed [10:0] CLAMP_MAX = 11'sd255;

	// Floor divide by 256, add offset, clamp to 0..255
	function automatic logic [7:0] scale_clamp(input logic signed [17:0] sum,
		input logic signed [10:0] offset);
		logic signed [10:0] v;
		v = $signed({sum[17], sum[17:8]}) + offset;
		if (v < 11'sd0) begin
			scale_clamp = 8'd0;
		end else if (v > CLAMP_MAX) begin
			scale_clamp = 8'd255;
		end else begin
			scale_clamp = v[7:0];
		end
	endfunction

endpackage

@@ sv/rgb24_to_yuv420_pixel_stream_top.sv @@
// Top level of the RGB24 to YUV 4:2:0 pixel stream converter.
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  in_data  (red, green, blue)
//   out      out        out_valid/ out_stall out_data (luma, chroma, chroma_kind, ends)
//   cfg      in         cfg_valid/ cfg_ready cfg_index, cfg_data (line width, frame height)
//
// One item per clock sustained while out_stall is low; an item's result shows at
// out_data once it passes from the input register into the result register.
// The raster counters advance when an item is accepted, so position flags are
// fixed at that edge; the colour matrix sits between the two registers.
// Reset clears the counters and the valid flags and loads 640 by 480 into the
// dimension registers.
// A stalled result holds the result register; the input register still takes
// an item while it is empty, and in_stall rises only when both are full.
module rgb24_to_yuv420_pixel_stream_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ry420_pkg::pixel_in_t           in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ry420_pkg::pixel_out_t          out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  ry420_pkg::cfg_reg_t            cfg_index,
	input  logic [ry420_pkg::CFG_W-1:0]    cfg_data
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int EW    = (ry420_pkg::CFG_W > DIM_W) ? ry420_pkg::CFG_W : DIM_W;
	localparam logic [EW-1:0] MAX_E = EW'(MAX_DIM);

	// Dimension registers
	logic [ry420_pkg::CFG_W-1:0] line_width_q;
	logic [ry420_pkg::CFG_W-1:0] frame_height_q;

	// Raster position of the next item
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;

	// Input register
	logic                    valid_s1;
	ry420_pkg::pixel_in_t    pix_s1;
	ry420_pkg::chroma_kind_t kind_s1;
	logic                    line_end_s1;
	logic                    frame_end_s1;

	// Result register
	logic                    out_valid_q;
	ry420_pkg::pixel_out_t   out_q;

	logic                    adv_out;
	logic                    adv_s1;
	logic                    in_acc;
	logic [EW-1:0]           w_eff;
	logic [EW-1:0]           h_eff;
	logic [EW-1:0]           line_width_e;
	logic [EW-1:0]           frame_height_e;
	logic                    last_col;
	logic                    last_row;
	ry420_pkg::chroma_kind_t kind_d;
	logic signed [17:0]      r_x;
	logic signed [17:0]      g_x;
	logic signed [17:0]      b_x;
	logic signed [17:0]      y_sum;
	logic signed [17:0]      u_sum;
	logic signed [17:0]      v_sum;
	ry420_pkg::pixel_out_t   res_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= ry420_pkg::LINE_WIDTH_RST;
			frame_height_q <= ry420_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ry420_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data;
				ry420_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero acts as one, anything above the maximum acts as the maximum
	assign line_width_e   = EW'(line_width_q);
	assign frame_height_e = EW'(frame_height_q);

	always_comb begin
		if (line_width_e == '0) begin
			w_eff = EW'(1);
		end else if (line_width_e > MAX_E) begin
			w_eff = MAX_E;
		end else begin
			w_eff = line_width_e;
		end
		if (frame_height_e == '0) begin
			h_eff = EW'(1);
		end else if (frame_height_e > MAX_E) begin
			h_eff = MAX_E;
		end else begin
			h_eff = frame_height_e;
		end
	end

	// At or past the last position counts as last, so a shrunk size wraps at once
	assign last_col = (EW'(col_q) + EW'(1)) >= w_eff;
	assign last_row = (EW'(row_q) + EW'(1)) >= h_eff;

	always_comb begin
		if (col_q[0]) begin
			kind_d = ry420_pkg::CK_NONE;
		end else if (row_q[0]) begin
			kind_d = ry420_pkg::CK_V;
		end else begin
			kind_d = ry420_pkg::CK_U;
		end
	end

	// Handshake: the result register moves when empty or taken, the input
	// register moves when empty or when it can pass its item on
	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s1   = !valid_s1 || adv_out;
	assign in_stall = !adv_s1;
	assign in_acc   = in_valid && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the pixel and its raster flags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1       <= in_data;
			kind_s1      <= kind_d;
			line_end_s1  <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	// Colour matrix: constant multiplies and one add of three products and the rounding constant per component
	assign r_x = $signed({10'd0, pix_s1.red});
	assign g_x = $signed({10'd0, pix_s1.green});
	assign b_x = $signed({10'd0, pix_s1.blue});

	assign y_sum = ry420_pkg::Y_R * r_x + ry420_pkg::Y_G * g_x + ry420_pkg::Y_B * b_x
		+ ry420_pkg::ROUND;
	assign u_sum = ry420_pkg::U_R * r_x + ry420_pkg::U_G * g_x + ry420_pkg::U_B * b_x
		+ ry420_pkg::ROUND;
	assign v_sum = ry420_pkg::V_R * r_x + ry420_pkg::V_G * g_x + ry420_pkg::V_B * b_x
		+ ry420_pkg::ROUND;

	always_comb begin
		res_d.luma        = ry420_pkg::scale_clamp(y_sum, ry420_pkg::Y_OFFSET);
		res_d.chroma_kind = kind_s1;
		res_d.line_end    = line_end_s1;
		res_d.frame_end   = frame_end_s1;
		case (kind_s1)
			ry420_pkg::CK_U: res_d.chroma = ry420_pkg::scale_clamp(u_sum, ry420_pkg::C_OFFSET);
			ry420_pkg::CK_V: res_d.chroma = ry420_pkg::scale_clamp(v_sum, ry420_pkg::C_OFFSET);
			default:         res_d.chroma = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	// Hold the result while stalled
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ tb/yuv_scoreboard_pkg.sv @@
// Scoreboard class for the RGB24 to YUV 4:2:0 pixel stream testbench.
`timescale 1ns / 100ps

package yuv_scoreboard_pkg;

	class yuv_scoreboard;

		int                           dim_limit;
		logic [ry420_pkg::CFG_W-1:0]  line_width;
		logic [ry420_pkg::CFG_W-1:0]  frame_height;
		int                           column_pos;
		int                           row_pos;
		ry420_pkg::pixel_out_t        yuv_expected_q[$];
		int                           mismatches;
		int                           results_seen;

		function new(int max_dim);
			dim_limit    = max_dim;
			line_width   = ry420_pkg::LINE_WIDTH_RST;
			frame_height = ry420_pkg::FRAME_HEIGHT_RST;
			column_pos   = 0;
			row_pos      = 0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_dim(ry420_pkg::cfg_reg_t index, logic [ry420_pkg::CFG_W-1:0] value);
			case (index)
				ry420_pkg::REG_LINE_WIDTH: begin
					line_width = value;
				end
				ry420_pkg::REG_FRAME_HEIGHT: begin
					frame_height = value;
				end
				default: begin
				end
			endcase
		endfunction

		// Zero acts as one, anything past the limit acts as the limit
		function int clip_dim(logic [ry420_pkg::CFG_W-1:0] value);
			if (value == '0) begin
				return 1;
			end
			if (int'(value) > dim_limit) begin
				return dim_limit;
			end
			return int'(value);
		endfunction

		// Floor divide by 256 after rounding, add offset, clamp to a byte
		function logic [7:0] scale_offset(int sum, int offset);
			int v;
			v = ((sum + 128) >>> 8) + offset;
			if (v < 0) begin
				v = 0;
			end
			if (v > 255) begin
				v = 255;
			end
			return v[7:0];
		endfunction

		function void note_pixel(ry420_pkg::pixel_in_t pix);
			int                    r;
			int                    g;
			int                    b;
			int                    w;
			int                    h;
			bit                    last_col;
			bit                    last_row;
			ry420_pkg::pixel_out_t yuv;
			r = int'(pix.red);
			g = int'(pix.green);
			b = int'(pix.blue);
			w = clip_dim(line_width);
			h = clip_dim(frame_height);
			last_col = (column_pos + 1) >= w;
			last_row = (row_pos + 1) >= h;
			yuv.luma = scale_offset(66 * r + 129 * g + 25 * b, 16);
			if ((column_pos % 2) != 0) begin
				yuv.chroma      = 8'd0;
				yuv.chroma_kind = ry420_pkg::CK_NONE;
			end else if ((row_pos % 2) == 0) begin
				yuv.chroma      = scale_offset(-38 * r - 74 * g + 112 * b, 128);
				yuv.chroma_kind = ry420_pkg::CK_U;
			end else begin
				yuv.chroma      = scale_offset(112 * r - 94 * g - 18 * b, 128);
				yuv.chroma_kind = ry420_pkg::CK_V;
			end
			yuv.line_end  = last_col;
			yuv.frame_end = last_col && last_row;
			yuv_expected_q.push_back(yuv);
			if (last_col) begin
				column_pos = 0;
				row_pos    = last_row ? 0 : row_pos + 1;
			end else begin
				column_pos = column_pos + 1;
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		task check_result(ry420_pkg::pixel_out_t got);
			ry420_pkg::pixel_out_t want;
			results_seen++;
			if (yuv_expected_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
				return;
			end
			want = yuv_expected_q.pop_front();
			if (got.luma !== want.luma) begin
				report_mismatch($sformatf("result %0d luma got %0d want %0d",
					results_seen, got.luma, want.luma));
			end
			if (got.chroma !== want.chroma) begin
				report_mismatch($sformatf("result %0d chroma got %0d want %0d",
					results_seen, got.chroma, want.chroma));
			end
			if (got.chroma_kind !== want.chroma_kind) begin
				report_mismatch($sformatf("result %0d chroma_kind got %0d want %0d",
					results_seen, got.chroma_kind, want.chroma_kind));
			end
			if (got.line_end !== want.line_end) begin
				report_mismatch($sformatf("result %0d line_end got %0b want %0b",
					results_seen, got.line_end, want.line_end));
			end
			if (got.frame_end !== want.frame_end) begin
				report_mismatch($sformatf("result %0d frame_end got %0b want %0b",
					results_seen, got.frame_end, want.frame_end));
			end
		endtask

		task flush_leftover();
			while (yuv_expected_q.size() > 0) begin
				void'(yuv_expected_q.pop_front());
				report_mismatch("expected result never arrived");
			end
		endtask

		function int pending();
			return yuv_expected_q.size();
		endfunction

	endclass

endpackage

@@ tb/rgb24_to_yuv420_pixel_stream_top_tb.sv @@
// Testbench top for the RGB24 to YUV 4:2:0 pixel stream converter.
`timescale 1ns / 100ps

module rgb24_to_yuv420_pixel_stream_top_tb;

	localparam int MAX_DIM = 4096;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	ry420_pkg::pixel_in_t           in_data = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	ry420_pkg::pixel_out_t          out_data;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	ry420_pkg::cfg_reg_t            cfg_index = ry420_pkg::REG_LINE_WIDTH;
	logic [ry420_pkg::CFG_W-1:0]    cfg_data = '0;

	yuv_scoreboard_pkg::yuv_scoreboard sb = new(MAX_DIM);

	// Raised by the stimulus to ask the receiver for one long hold-off
	bit                  want_hold = 1'b0;
	int                  pixels_sent = 0;
	int                  random_sent;
	int                  drain_cycles;

	rgb24_to_yuv420_pixel_stream_top #(
		.MAX_DIM(MAX_DIM)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Offer one pixel item, hold it until accepted, then note it for prediction.
	// Lower valid only for a gap, so a back-to-back item never sees valid dip.
	task automatic send_pixel(input ry420_pkg::pixel_in_t pix);
		in_valid <= 1'b1;
		in_data  <= pix;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_pixel(pix);
		pixels_sent++;
		// Idle now and then, except over one long stretch of back-to-back items
		if (!(pixels_sent >= 500 && pixels_sent < 800) && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Every combination of all-zero and all-one colour components
	task automatic send_corners();
		ry420_pkg::pixel_in_t pix;
		for (int i = 0; i < 8; i++) begin
			pix.red   = {8{i[2]}};
			pix.green = {8{i[1]}};
			pix.blue  = {8{i[0]}};
			send_pixel(pix);
		end
	endtask

	task automatic send_random(input int count);
		ry420_pkg::pixel_in_t pix;
		for (int i = 0; i < count; i++) begin
			pix.red   = 8'($urandom_range(0, 255));
			pix.green = 8'($urandom_range(0, 255));
			pix.blue  = 8'($urandom_range(0, 255));
			send_pixel(pix);
		end
	endtask

	// Hold the config strobe high across back-to-back writes; the caller drops it
	task automatic write_reg(input ry420_pkg::cfg_reg_t index,
		input logic [ry420_pkg::CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.set_dim(index, value);
	endtask

	// Stop sending, wait until every predicted result has come back, then
	// rewrite the dimensions. A negative value leaves that register alone.
	task automatic set_dims(input int width, input int height);
		in_valid <= 1'b0;
		while (sb.pending() > 0) begin
			@(posedge clk);
		end
		// Let the pipeline settle before touching the registers
		repeat (3) @(posedge clk);
		if (width >= 0) begin
			write_reg(ry420_pkg::REG_LINE_WIDTH, ry420_pkg::CFG_W'(width));
		end
		if (height >= 0) begin
			write_reg(ry420_pkg::REG_FRAME_HEIGHT, ry420_pkg::CFG_W'(height));
		end
		if (width >= 0 || height >= 0) begin
			cfg_valid <= 1'b0;
		end
	endtask

	// Receiver: check each accepted result, stall at random, hold off once on request
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(out_data);
			end
			if (want_hold) begin
				// Long hold-off: the sender keeps offering, so the block must fill and stall
				want_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (200) @(posedge clk);
			end else if (sb.results_seen >= 500 && sb.results_seen < 800) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 25);
			end
		end
	end

	// Stimulus
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dimensions: colour corners and bit patterns along the first row
		send_corners();
		send_pixel('{red: 8'h55, green: 8'hAA, blue: 8'h55});
		send_pixel('{red: 8'hAA, green: 8'h55, blue: 8'hAA});
		send_pixel('{red: 8'd1, green: 8'd128, blue: 8'd254});
		send_pixel('{red: 8'd128, green: 8'd128, blue: 8'd128});

		// Smallest even frame: U, V and no-chroma slots, line and frame ends
		set_dims(2, 2);
		send_corners();
		send_random(40);

		// Zero dimensions act as one: every pixel ends both line and frame
		set_dims(0, 0);
		send_random(20);

		// Odd dimensions are taken as given
		set_dims(1, 3);
		send_random(30);
		set_dims(3, 5);
		send_random(60);

		// Over-range dimensions clip to the maximum; advance the column well along
		set_dims(8191, 8191);
		send_random(150);

		// Shrink the line mid-frame: the column is past the new end and wraps at once.
		// Ask the receiver for a long hold-off while this batch streams in.
		set_dims(16, 4);
		want_hold = 1'b1;
		send_random(300);

		// Advance the row far, then shrink the frame height mid-frame
		set_dims(1, 4096);
		send_random(100);
		set_dims(-1, 3);
		send_random(20);

		// Exact maximum width and one past it
		set_dims(4096, 2);
		send_random(50);
		set_dims(4097, 1);
		send_random(20);

		// Random dimension changes, mostly small so line and frame ends come often
		random_sent = 0;
		while (random_sent < 440) begin
			int w;
			int h;
			int which;
			int count;
			which = $urandom_range(0, 3);
			w = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10)
				: ($urandom_range(0, 1) ? $urandom_range(11, 64) : $urandom_range(4090, 8191));
			h = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10)
				: ($urandom_range(0, 1) ? $urandom_range(11, 64) : $urandom_range(4090, 8191));
			count = $urandom_range(10, 120);
			case (which)
				0: set_dims(w, -1);
				1: set_dims(-1, h);
				default: set_dims(w, h);
			endcase
			send_random(count);
			random_sent += count;
		end

		// Drain with a limit, then give stray results a chance to show up
		in_valid <= 1'b0;
		drain_cycles = 0;
		while (sb.pending() > 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);
		sb.flush_leftover();
		if (sb.mismatches == 0) begin
			$display("rgb24_to_yuv420_pixel_stream_top_tb OK");
		end else begin
			$display("rgb24_to_yuv420_pixel_stream_top_tb NOT OK");
		end
		$finish;
	end

	// Watchdog: end a hung run
	initial begin
		#2_000_000;
		$display("rgb24_to_yuv420_pixel_stream_top_tb NOT OK");
		$finish;
	end

endmodule
